/* hdl/pngphy_pkg.sv */
// Shared constants and types for the PNG pHYs chunk inserter.
package pngphy_pkg;

  // CRC-32, reflected form
  localparam logic [31:0] CrcPoly = 32'hEDB88320;
  localparam logic [31:0] CrcInit = 32'hFFFFFFFF;

  // Held chunk header length and inserted chunk length in bytes
  localparam logic [3:0] HdrLen  = 4'd12;
  localparam logic [4:0] PhysLen = 5'd21;

  // Final status codes
  localparam logic [1:0] StatusOk     = 2'd0;
  localparam logic [1:0] StatusBadSig = 2'd1;
  localparam logic [1:0] StatusNoIdat = 2'd2;

  // Control from the sequencer to the CRC unit
  typedef struct packed {
    logic       init;
    logic       step;
    logic [7:0] data;
  } crc_ctl_t;

endpackage

/* hdl/png_phys_chunk_inserter_top.sv */
// PNG pHYs chunk inserter top level: configuration register and unit hookup.
//
// Passes a PNG byte stream through and places a 21-byte pHYs chunk ahead of
// the first IDAT chunk. Signature, skipped chunk bytes and everything after
// the insertion move at one byte per cycle while the output does not stall.
// Each 12-byte chunk header is held; on its last byte the block stops taking
// input while the held bytes, 33 with the pHYs chunk ahead of them, go out
// one byte per cycle through the output register unless the output stalls.
// The inserted chunk's CRC is built by a byte-wide CRC unit stepping once
// per emitted type or data byte. A final byte ending a partial header also
// flushes the held bytes. The last output byte's status reports a bad or
// short signature or a missing IDAT header. The user writes pixels_per_metre
// only while no transaction is in flight; the block does not enforce this.
module png_phys_chunk_inserter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  // input stream
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        is_final_i,
  // output stream
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        out_last_o,
  output logic [1:0]  status_o
);

  logic [31:0]          ppm_q;
  logic [31:0]          crc;
  pngphy_pkg::crc_ctl_t crc_ctl;

  // pixels_per_metre register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppm_q <= 32'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      ppm_q <= cfg_data_i;
    end
  end

  pngphy_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (crc_ctl),
    .crc_o  (crc)
  );

  pngphy_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .is_final_i  (is_final_i),
    .ppm_i       (ppm_q),
    .crc_ctl_o   (crc_ctl),
    .crc_i       (crc),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o),
    .status_o    (status_o)
  );

endmodule

/* hdl/pngphy_crc.sv */
// Byte-wide CRC-32 unit, one byte per step, used by the insertion sequence.
module pngphy_crc (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pngphy_pkg::crc_ctl_t ctl_i,
  output logic [31:0]         crc_o
);

  logic [31:0] crc_q, crc_d;

  function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? (pngphy_pkg::CrcPoly ^ (r >> 1)) : (r >> 1);
    end
    return r;
  endfunction

  // next CRC value
  always_comb begin
    crc_d = crc_q;
    if (ctl_i.init) begin
      crc_d = pngphy_pkg::CrcInit;
    end else if (ctl_i.step) begin
      crc_d = crc_next(crc_q, ctl_i.data);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= pngphy_pkg::CrcInit;
    end else begin
      crc_q <= crc_d;
    end
  end

  // final xor applied on the way out
  assign crc_o = ~crc_q;

endmodule

/* hdl/pngphy_ctrl.sv */
// Stream sequencer: signature check, chunk walk, header hold, insertion and flush.
module pngphy_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           data_byte_i,
  input  logic                 is_final_i,
  input  logic [31:0]          ppm_i,
  output pngphy_pkg::crc_ctl_t crc_ctl_o,
  input  logic [31:0]          crc_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           out_byte_o,
  output logic                 out_last_o,
  output logic [1:0]           status_o
);

  typedef enum logic [2:0] {
    SEQ_IDLE  = 3'b001,
    SEQ_INS   = 3'b010,
    SEQ_FLUSH = 3'b100
  } seq_e;

  typedef enum logic [3:0] {
    PH_SIG  = 4'b0001,
    PH_HEAD = 4'b0010,
    PH_SKIP = 4'b0100,
    PH_PASS = 4'b1000
  } phase_e;

  seq_e        seq_q, seq_d;
  phase_e      phase_q, phase_d;
  logic [2:0]  sig_idx_q, sig_idx_d;
  logic        sig_bad_q, sig_bad_d;
  logic [3:0]  fill_q, fill_d;
  logic [31:0] skip_q, skip_d;
  logic        ins_done_q, ins_done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [3:0]  flen_q, flen_d;
  logic        fin_q, fin_d;
  logic [1:0]  fstat_q, fstat_d;
  logic [7:0]  hbuf_q [12];
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        out_last_q;
  logic [1:0]  out_status_q;

  logic        out_free;
  logic        accept;
  logic        hdr_we;
  logic        emit;
  logic [7:0]  emit_byte;
  logic        emit_last;
  logic [1:0]  emit_status;
  logic [1:0]  stat;
  logic [31:0] hdr_len;
  logic        hdr_idat;
  logic [7:0]  phys_b;

  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = 8'h89;
      3'd1:    r = 8'h50;
      3'd2:    r = 8'h4E;
      3'd3:    r = 8'h47;
      3'd4:    r = 8'h0D;
      3'd5:    r = 8'h0A;
      3'd6:    r = 8'h1A;
      default: r = 8'h0A;
    endcase
    return r;
  endfunction

  // byte k of the inserted chunk: length, type, X, Y, unit, CRC
  function automatic logic [7:0] phys_byte(input logic [4:0] k, input logic [31:0] ppm,
                                           input logic [31:0] crc);
    logic [7:0] r;
    case (k)
      5'd3:    r = 8'd9;
      5'd4:    r = 8'h70;
      5'd5:    r = 8'h48;
      5'd6:    r = 8'h59;
      5'd7:    r = 8'h73;
      5'd8:    r = ppm[31:24];
      5'd9:    r = ppm[23:16];
      5'd10:   r = ppm[15:8];
      5'd11:   r = ppm[7:0];
      5'd12:   r = ppm[31:24];
      5'd13:   r = ppm[23:16];
      5'd14:   r = ppm[15:8];
      5'd15:   r = ppm[7:0];
      5'd16:   r = 8'h01;
      5'd17:   r = crc[31:24];
      5'd18:   r = crc[23:16];
      5'd19:   r = crc[15:8];
      5'd20:   r = crc[7:0];
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign accept     = in_valid_i && (seq_q == SEQ_IDLE) && out_free;
  assign in_stall_o = !((seq_q == SEQ_IDLE) && out_free);

  // decode of the held header
  assign hdr_len  = {hbuf_q[0], hbuf_q[1], hbuf_q[2], hbuf_q[3]};
  assign hdr_idat = (hbuf_q[4] == 8'h49) && (hbuf_q[5] == 8'h44) &&
                    (hbuf_q[6] == 8'h41) && (hbuf_q[7] == 8'h54);
  assign phys_b   = phys_byte(cnt_q, ppm_i, crc_i);

  // sequencer
  always_comb begin
    seq_d       = seq_q;
    phase_d     = phase_q;
    sig_idx_d   = sig_idx_q;
    sig_bad_d   = sig_bad_q;
    fill_d      = fill_q;
    skip_d      = skip_q;
    ins_done_d  = ins_done_q;
    cnt_d       = cnt_q;
    flen_d      = flen_q;
    fin_d       = fin_q;
    fstat_d     = fstat_q;
    hdr_we      = 1'b0;
    emit        = 1'b0;
    emit_byte   = data_byte_i;
    emit_last   = 1'b0;
    emit_status = pngphy_pkg::StatusOk;
    stat        = pngphy_pkg::StatusOk;
    crc_ctl_o   = '0;

    if (accept) begin
      case (phase_q)
        PH_SIG: begin
          emit      = 1'b1;
          if (data_byte_i != sig_byte(sig_idx_q)) begin
            sig_bad_d = 1'b1;
          end
          sig_idx_d = sig_idx_q + 3'd1;
          if (sig_idx_q == 3'd7) begin
            phase_d = sig_bad_d ? PH_PASS : PH_HEAD;
          end
        end
        PH_HEAD: begin
          hdr_we = 1'b1;
          if (fill_q == pngphy_pkg::HdrLen - 4'd1) begin
            fill_d = 4'd0;
            flen_d = pngphy_pkg::HdrLen;
            cnt_d  = 5'd0;
            if (!ins_done_q && hdr_idat) begin
              seq_d          = SEQ_INS;
              ins_done_d     = 1'b1;
              crc_ctl_o.init = 1'b1;
              phase_d        = PH_PASS;
            end else begin
              seq_d   = SEQ_FLUSH;
              skip_d  = hdr_len;
              phase_d = (hdr_len == 32'd0) ? PH_HEAD : PH_SKIP;
            end
          end else if (is_final_i) begin
            // truncated header: flush what is held
            seq_d  = SEQ_FLUSH;
            cnt_d  = 5'd0;
            flen_d = fill_q + 4'd1;
            fill_d = 4'd0;
          end else begin
            fill_d = fill_q + 4'd1;
          end
        end
        PH_SKIP: begin
          emit   = 1'b1;
          skip_d = skip_q - 32'd1;
          if (skip_q == 32'd1) begin
            phase_d = PH_HEAD;
          end
        end
        default: begin
          emit = 1'b1;
        end
      endcase

      // end-of-stream status from the updated state
      if (sig_bad_d || (phase_d == PH_SIG)) begin
        stat = pngphy_pkg::StatusBadSig;
      end else if (!ins_done_d) begin
        stat = pngphy_pkg::StatusNoIdat;
      end
      emit_last   = is_final_i;
      emit_status = is_final_i ? stat : pngphy_pkg::StatusOk;
      fin_d       = is_final_i;
      fstat_d     = stat;

      // stream restarts after its final byte
      if (is_final_i) begin
        phase_d    = PH_SIG;
        sig_idx_d  = 3'd0;
        sig_bad_d  = 1'b0;
        fill_d     = 4'd0;
        skip_d     = 32'd0;
        ins_done_d = 1'b0;
      end
    end else if ((seq_q == SEQ_INS) && out_free) begin
      emit      = 1'b1;
      emit_byte = phys_b;
      if ((cnt_q >= 5'd4) && (cnt_q <= 5'd16)) begin
        crc_ctl_o.step = 1'b1;
        crc_ctl_o.data = phys_b;
      end
      if (cnt_q == pngphy_pkg::PhysLen - 5'd1) begin
        seq_d = SEQ_FLUSH;
        cnt_d = 5'd0;
      end else begin
        cnt_d = cnt_q + 5'd1;
      end
    end else if ((seq_q == SEQ_FLUSH) && out_free) begin
      emit      = 1'b1;
      emit_byte = hbuf_q[cnt_q[3:0]];
      cnt_d     = cnt_q + 5'd1;
      if (cnt_q[3:0] == flen_q - 4'd1) begin
        emit_last   = fin_q;
        emit_status = fin_q ? fstat_q : pngphy_pkg::StatusOk;
        seq_d       = SEQ_IDLE;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= SEQ_IDLE;
      phase_q     <= PH_SIG;
      sig_idx_q   <= 3'd0;
      sig_bad_q   <= 1'b0;
      fill_q      <= 4'd0;
      skip_q      <= 32'd0;
      ins_done_q  <= 1'b0;
      cnt_q       <= 5'd0;
      flen_q      <= 4'd0;
      fin_q       <= 1'b0;
      fstat_q     <= pngphy_pkg::StatusOk;
      out_valid_q <= 1'b0;
    end else begin
      seq_q      <= seq_d;
      phase_q    <= phase_d;
      sig_idx_q  <= sig_idx_d;
      sig_bad_q  <= sig_bad_d;
      fill_q     <= fill_d;
      skip_q     <= skip_d;
      ins_done_q <= ins_done_d;
      cnt_q      <= cnt_d;
      flen_q     <= flen_d;
      fin_q      <= fin_d;
      fstat_q    <= fstat_d;
      if (out_free) begin
        out_valid_q <= emit;
      end
    end
  end

  // header hold buffer
  always_ff @(posedge clk_i) begin
    if (hdr_we) begin
      hbuf_q[fill_q] <= data_byte_i;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q   <= emit_byte;
      out_last_q   <= emit_last;
      out_status_q <= emit_status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;
  assign status_o    = out_status_q;

endmodule

/* tb/sv/png_phys_chunk_inserter_top_tb.sv */
// Self-checking testbench for the PNG pHYs chunk inserter top level.
module png_phys_chunk_inserter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit   = 1_000_000;
  localparam int unsigned ItemTarget   = 420;
  localparam int unsigned CalmFrom     = 360;
  localparam int unsigned HoldAt       = 200;
  localparam int unsigned HoldCycles   = 250;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned CfgEvery     = 80;
  localparam int unsigned PrintCap     = 200;

  localparam logic [63:0] PngSig      = 64'h8950_4E47_0D0A_1A0A;
  localparam logic [31:0] IdatTag     = "IDAT";
  localparam logic [31:0] IendTag     = "IEND";
  localparam logic [31:0] PhysTag     = "pHYs";
  localparam logic [7:0]  PhysDataLen = 8'd9;
  localparam logic [7:0]  PhysUnit    = 8'h01;

  typedef enum int unsigned {
    StreamClean,
    StreamCutHeader,
    StreamBadSig,
    StreamShortSig,
    StreamNoise
  } stream_kind_e;

  // Tracks the chunk walk and holds the output bytes still to come
  class phys_insert_scoreboard;
    typedef enum logic [1:0] {WalkSig, WalkHead, WalkSkip, WalkPass} walk_e;
    typedef struct {
      logic [7:0] data;
      logic       last;
      logic [1:0] status;
    } out_beat_t;

    logic [31:0] pixels_per_metre;
    walk_e       walk;
    int unsigned sig_idx;
    bit          sig_bad;
    logic [7:0]  hdr [12];
    int unsigned hdr_fill;
    logic [31:0] skip_left;
    bit          inserted;
    logic [31:0] phys_crc;
    logic [7:0]  step_bytes [$];
    out_beat_t   awaited_bytes [$];
    int unsigned mismatches;

    function new();
      pixels_per_metre = '0;
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      walk = WalkSig;
      sig_idx = 0;
      sig_bad = 0;
      hdr_fill = 0;
      skip_left = '0;
      inserted = 0;
      phys_crc = pngphy_pkg::CrcInit;
    endfunction

    // append one byte to the output of the current step
    function void queue_byte(logic [7:0] b);
      step_bytes.insert(step_bytes.size(), b);
    endfunction

    // one byte through the reflected CRC-32, then out
    function void emit_crc_byte(logic [7:0] b);
      int k;
      phys_crc ^= {24'h0, b};
      for (k = 0; k < 8; k++) begin
        phys_crc = phys_crc[0] ? ((phys_crc >> 1) ^ pngphy_pkg::CrcPoly) : (phys_crc >> 1);
      end
      queue_byte(b);
    endfunction

    function void emit_phys();
      logic [7:0] body [13];
      int i;
      for (i = 0; i < 4; i++) begin
        body[i]     = PhysTag[31-8*i -: 8];
        body[4 + i] = pixels_per_metre[31-8*i -: 8];
        body[8 + i] = pixels_per_metre[31-8*i -: 8];
      end
      body[12] = PhysUnit;
      queue_byte(8'h00);
      queue_byte(8'h00);
      queue_byte(8'h00);
      queue_byte(PhysDataLen);
      phys_crc = pngphy_pkg::CrcInit;
      for (i = 0; i < 13; i++) emit_crc_byte(body[i]);
      phys_crc ^= 32'hFFFF_FFFF;
      for (i = 0; i < 4; i++) queue_byte(phys_crc[31-8*i -: 8]);
    endfunction

    function void flush_hdr();
      int unsigned i;
      for (i = 0; i < hdr_fill; i++) queue_byte(hdr[i]);
      hdr_fill = 0;
    endfunction

    // accepted input transaction: work out the output bytes it releases
    function void take_stream_byte(logic [7:0] b, logic fin);
      logic [1:0] code;
      out_beat_t beat;
      step_bytes.delete();
      case (walk)
        WalkSig: begin
          if (b != PngSig[63-8*sig_idx -: 8]) sig_bad = 1;
          queue_byte(b);
          sig_idx = (sig_idx + 1) % 8;
          if (sig_idx == 0) walk = sig_bad ? WalkPass : WalkHead;
        end
        WalkHead: begin
          hdr[hdr_fill] = b;
          hdr_fill++;
          if (hdr_fill == 12) begin
            if (!inserted && {hdr[4], hdr[5], hdr[6], hdr[7]} == IdatTag) begin
              emit_phys();
              inserted = 1;
              flush_hdr();
              walk = WalkPass;
            end else begin
              skip_left = {hdr[0], hdr[1], hdr[2], hdr[3]};
              flush_hdr();
              walk = (skip_left == 0) ? WalkHead : WalkSkip;
            end
          end else if (fin) begin
            flush_hdr();
          end
        end
        WalkSkip: begin
          queue_byte(b);
          skip_left--;
          if (skip_left == 0) walk = WalkHead;
        end
        default: queue_byte(b);
      endcase

      code = pngphy_pkg::StatusOk;
      if (fin) begin
        if (sig_bad || walk == WalkSig) code = pngphy_pkg::StatusBadSig;
        else if (!inserted) code = pngphy_pkg::StatusNoIdat;
      end
      foreach (step_bytes[i]) begin
        beat.data   = step_bytes[i];
        beat.last   = fin && (i == step_bytes.size() - 1);
        beat.status = beat.last ? code : pngphy_pkg::StatusOk;
        awaited_bytes.insert(awaited_bytes.size(), beat);
      end
      if (fin) restart();
    endfunction

    task report(string msg);
      if (mismatches < PrintCap) $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    // accepted output transaction against the oldest awaited byte
    task check_out_byte(logic [7:0] b, logic last, logic [1:0] status);
      out_beat_t want;
      if (awaited_bytes.size() == 0) begin
        report($sformatf("output byte %02h with nothing awaited", b));
      end else begin
        want = awaited_bytes.pop_front();
        if (b !== want.data)
          report($sformatf("out_byte %02h, expected %02h", b, want.data));
        if (last !== want.last)
          report($sformatf("out_last %0b, expected %0b (byte %02h)", last, want.last, b));
        if (status !== want.status)
          report($sformatf("status %0d, expected %0d (byte %02h)", status, want.status, b));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data = '0;
  logic        in_final = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        out_last;
  logic [1:0]  out_status;

  phys_insert_scoreboard sb;
  logic [7:0]  pending_q [$];
  int unsigned sent_count = 0;
  int unsigned cycle_count = 0;
  bit          calm = 0;
  bit          long_hold = 0;

  png_phys_chunk_inserter_top DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .data_byte_i (in_data),
    .is_final_i  (in_final),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_byte_o  (out_byte),
    .out_last_o  (out_last),
    .status_o    (out_status)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Monitors: input first, so a same-edge result already has its expectation
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.take_stream_byte(in_data, in_final);
      if (out_valid && !out_stall) sb.check_out_byte(out_byte, out_last, out_status);
    end
  end

  // Run limit
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Output side back-pressure: random bursts, one long hold on request
  initial begin : out_stall_gen
    logic hold;
    int unsigned span;
    forever begin
      if (calm) begin
        hold = 1'b0;
        span = 1;
      end else if (long_hold) begin
        hold = 1'b1;
        span = HoldCycles;
        long_hold = 0;
      end else if ($urandom_range(0, 3) == 0) begin
        hold = 1'b1;
        span = $urandom_range(1, 13);
      end else begin
        hold = 1'b0;
        span = $urandom_range(1, 20);
      end
      out_stall <= hold;
      repeat (span) @(posedge clk);
    end
  end

  // Stream byte transaction, with an occasional idle burst ahead of it
  task automatic send_byte(logic [7:0] b, logic last);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    in_final <= last;
    do @(posedge clk); while (in_stall);
    sent_count++;
  endtask

  task automatic send_stream();
    foreach (pending_q[i]) send_byte(pending_q[i], i == pending_q.size() - 1);
    pending_q.delete();
  endtask

  // Drop valid and let the block empty out, including header-only work
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.awaited_bytes.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_ppm(logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.pixels_per_metre = value;
  endtask

  // append one byte to the stream being built
  function automatic void stage_byte(logic [7:0] b);
    pending_q.insert(pending_q.size(), b);
  endfunction

  function automatic void add_sig();
    int i;
    for (i = 0; i < 8; i++) stage_byte(PngSig[63-8*i -: 8]);
  endfunction

  // length, type, then data and CRC bytes with random content
  function automatic void add_chunk(logic [31:0] tag, int unsigned len);
    logic [31:0] len_field;
    int i;
    len_field = len;
    for (i = 0; i < 4; i++) stage_byte(len_field[31-8*i -: 8]);
    for (i = 0; i < 4; i++) stage_byte(tag[31-8*i -: 8]);
    repeat (len + 4) stage_byte(8'($urandom));
  endfunction

  function automatic logic [31:0] pick_tag();
    case ($urandom_range(0, 6))
      0: return "IHDR";
      1: return "gAMA";
      2: return "tEXt";
      3: return IendTag;
      4: return "IDAt";
      5: return "iDAT";
      default: return $urandom;
    endcase
  endfunction

  function automatic void trim_to(int unsigned keep);
    while (pending_q.size() > keep) void'(pending_q.pop_back());
  endfunction

  function automatic void build_stream(stream_kind_e kind);
    int unsigned base;
    int unsigned idx;
    pending_q.delete();
    case (kind)
      StreamClean: begin
        add_sig();
        repeat ($urandom_range(0, 2)) add_chunk(pick_tag(), $urandom_range(0, 6));
        add_chunk(IdatTag, $urandom_range(0, 10));
        if ($urandom_range(0, 2) == 0) add_chunk(IdatTag, $urandom_range(0, 4));
        if ($urandom_range(0, 1) == 0) add_chunk(pick_tag(), $urandom_range(0, 4));
        add_chunk(IendTag, 0);
        // end early somewhere: in a skip, a header or after the insertion
        if ($urandom_range(0, 3) == 0) trim_to($urandom_range(1, pending_q.size()));
      end
      StreamCutHeader: begin
        add_sig();
        if ($urandom_range(0, 1) == 0) add_chunk(pick_tag(), $urandom_range(0, 4));
        base = pending_q.size();
        add_chunk($urandom_range(0, 1) ? IdatTag : pick_tag(), 0);
        trim_to(base + $urandom_range(1, 11));
      end
      StreamBadSig: begin
        add_sig();
        idx = $urandom_range(0, 7);
        pending_q[idx] = pending_q[idx] ^ 8'($urandom_range(1, 255));
        add_chunk(IdatTag, $urandom_range(0, 6));
      end
      StreamShortSig: begin
        add_sig();
        trim_to($urandom_range(1, 7));
      end
      default: begin
        if ($urandom_range(0, 1) == 0) add_sig();
        repeat ($urandom_range(1, 30)) stage_byte(8'($urandom));
      end
    endcase
  endfunction

  function automatic stream_kind_e pick_kind();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 12) return StreamClean;
    if (r < 14) return StreamCutHeader;
    if (r < 16) return StreamBadSig;
    if (r < 17) return StreamShortSig;
    return StreamNoise;
  endfunction

  // Main sequence
  initial begin
    int unsigned cfg_step;
    int unsigned next_cfg_at;
    bit hold_done;
    logic [31:0] ppm;

    sb = new();
    cfg_step = 0;
    hold_done = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_ppm(32'h0000_0000);

    // Directed: IDAT right after the signature, zero length, all-ones CRC field
    add_sig();
    add_chunk(IdatTag, 0);
    pending_q[16] = 8'hFF;
    pending_q[17] = 8'hFF;
    pending_q[18] = 8'hFF;
    pending_q[19] = 8'hFF;
    send_stream();
    // Directed: signature cut short and wrong from the first byte
    stage_byte(8'h00);
    stage_byte(8'hFF);
    send_stream();

    // Random streams, new register value every so often
    next_cfg_at = sent_count;
    while (sent_count < ItemTarget) begin
      if (sent_count >= next_cfg_at) begin
        wait_drained();
        case (cfg_step)
          0: ppm = 32'hFFFF_FFFF;
          2: ppm = 32'h0000_0001;
          3: ppm = 32'h8000_0000;
          default: ppm = $urandom;
        endcase
        write_ppm(ppm);
        cfg_step++;
        next_cfg_at = sent_count + CfgEvery;
      end
      if (!hold_done && sent_count >= HoldAt) begin
        long_hold = 1;
        hold_done = 1;
      end
      if (sent_count >= CalmFrom) calm = 1;
      build_stream(pick_kind());
      send_stream();
    end

    calm = 1;
    wait_drained();
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/pngphy_pkg.sv
hdl/pngphy_crc.sv
hdl/pngphy_ctrl.sv
hdl/png_phys_chunk_inserter_top.sv
tb/sv/png_phys_chunk_inserter_top_tb.sv
